### rtl/route_update_message_checker_macros.svh
// Assertion macros for the route UPDATE message checker.
// Define SYNTH to compile every check away.
`ifndef ROUTE_UPDATE_MESSAGE_CHECKER_MACROS_SVH
`define ROUTE_UPDATE_MESSAGE_CHECKER_MACROS_SVH

`ifndef SYNTH

// Condition implies consequence in the same cycle
`define RUMC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle
`define RUMC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`else

`define RUMC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg)
`define RUMC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg)

`endif

`endif

### rtl/rumc_pkg.sv
package rumc_pkg;

    // Request codes
    localparam logic [2:0] REQ_START     = 3'd0;
    localparam logic [2:0] REQ_ATTR      = 3'd1;
    localparam logic [2:0] REQ_ATTR_END  = 3'd2;
    localparam logic [2:0] REQ_NLRI_BYTE = 3'd3;
    localparam logic [2:0] REQ_MSG_END   = 3'd4;

    // Status codes
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_LIST    = 4'd1;
    localparam logic [3:0] ST_MISSING = 4'd2;
    localparam logic [3:0] ST_FLAGS   = 4'd3;
    localparam logic [3:0] ST_LENGTH  = 4'd4;
    localparam logic [3:0] ST_ORIGIN  = 4'd5;
    localparam logic [3:0] ST_NEXTHOP = 4'd6;
    localparam logic [3:0] ST_NETWORK = 4'd7;
    localparam logic [3:0] ST_ASPATH  = 4'd8;

    // Attribute type codes
    localparam logic [2:0] ATTR_ORIGIN     = 3'd1;
    localparam logic [2:0] ATTR_AS_PATH    = 3'd2;
    localparam logic [2:0] ATTR_NEXT_HOP   = 3'd3;
    localparam logic [2:0] ATTR_MED        = 3'd4;
    localparam logic [2:0] ATTR_LOCAL_PREF = 3'd5;
    localparam logic [2:0] ATTR_ATOMIC_AGG = 3'd6;
    localparam logic [2:0] ATTR_AGGREGATOR = 3'd7;

    // Fixed header overhead of an UPDATE message in bytes
    localparam logic [14:0] MSG_OVERHEAD = 15'd23;
    // Longest legal prefix in bits
    localparam logic [7:0] MAX_PREFIX_BITS = 8'd32;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [12:0] message_length;
        logic [12:0] withdrawn_length;
        logic [12:0] attributes_length;
        logic [7:0]  attr_type;
        logic [7:0]  attr_flags;
        logic [15:0] attr_length;
        logic [31:0] value_word;
        logic        as_path_ok;
        logic [7:0]  nlri_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [1:0] missing_attr;
        logic       verdict_done;
        logic       message_valid;
    } out_item_t;

endpackage

### rtl/route_update_message_checker.sv
// Route UPDATE message checker. Feed one message as a start item with the
// lengths, one item per path attribute, an attributes-end item, one item per
// reachability byte and a message-end item. Every item gives one result with
// the latched status (first error wins); the message-end result also carries
// verdict_done and message_valid. An item passes through an input register and
// a result register, from which its result is offered; throughput is one item
// per cycle while the result side does not stall, set only by the state update
// between the two registers. The stall on the item side follows the stall on
// the result side while both registers hold an item.
`include "route_update_message_checker_macros.svh"

module route_update_message_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rumc_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output rumc_pkg::out_item_t result
);

    rumc_pkg::in_item_t  item_reg;
    logic                item_valid_reg;
    rumc_pkg::out_item_t result_reg;
    logic                result_valid_reg;

    logic [6:0] seen_reg, seen_next;
    logic [3:0] err_reg, err_next;
    logic [1:0] miss_reg, miss_next;
    logic [2:0] left_reg, left_next;
    logic       present_reg, present_next;
    logic       done;
    logic       advance;

    logic [14:0] len_sum;
    logic [6:0]  type_bit;
    logic [3:0]  attr_err;
    logic        hop_ok;
    logic [6:0]  prefix_round;

    // Move the held item on when the result register is free or being taken
    assign advance    = item_valid_reg && !(result_valid_reg && result_stall);
    assign item_stall = item_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    // Next-hop address screening: zero, multicast, 10/8, 172.16/16 and 192.168.0/24
    always_comb
    begin
        hop_ok = 1'b1;
        if (item_reg.value_word == 32'h0000_0000)
            hop_ok = 1'b0;
        if (item_reg.value_word[31:28] == 4'hE)
            hop_ok = 1'b0;
        if (item_reg.value_word[31:24] == 8'h0A)
            hop_ok = 1'b0;
        if (item_reg.value_word[31:16] == 16'hAC10)
            hop_ok = 1'b0;
        if (item_reg.value_word[31:8] == 24'hC0A800)
            hop_ok = 1'b0;
    end

    // Per-item state update
    always_comb
    begin
        seen_next    = seen_reg;
        err_next     = err_reg;
        miss_next    = miss_reg;
        left_next    = left_reg;
        present_next = present_reg;
        done         = 1'b0;
        attr_err     = rumc_pkg::ST_OK;
        len_sum      = 15'({2'b00, item_reg.withdrawn_length})
                     + 15'({2'b00, item_reg.attributes_length})
                     + rumc_pkg::MSG_OVERHEAD;
        type_bit     = 7'd1 << (item_reg.attr_type[2:0] - 3'd1);
        prefix_round = {1'b0, item_reg.nlri_byte[5:0]} + 7'd7;

        case (item_reg.req_type)
            rumc_pkg::REQ_START:
            begin
                seen_next    = 7'd0;
                miss_next    = 2'd0;
                left_next    = 3'd0;
                present_next = (item_reg.attributes_length != 13'd0);
                err_next     = ({2'b00, item_reg.message_length} < len_sum) ?
                               rumc_pkg::ST_LIST : rumc_pkg::ST_OK;
            end
            rumc_pkg::REQ_ATTR:
            begin
                if (err_reg == rumc_pkg::ST_OK && present_reg)
                begin
                    // Known types: duplicate, length and value rules
                    if (item_reg.attr_type[7:3] == 5'd0 && item_reg.attr_type[2:0] != 3'd0)
                    begin
                        if ((seen_reg & type_bit) != 7'd0)
                        begin
                            attr_err = rumc_pkg::ST_LIST;
                        end
                        else
                        begin
                            seen_next = seen_reg | type_bit;
                            case (item_reg.attr_type[2:0]) inside
                                rumc_pkg::ATTR_ORIGIN:
                                begin
                                    if (item_reg.attr_length != 16'd1)
                                        attr_err = rumc_pkg::ST_LENGTH;
                                    else if (item_reg.value_word[31:24] > 8'd2)
                                        attr_err = rumc_pkg::ST_ORIGIN;
                                end
                                rumc_pkg::ATTR_AS_PATH:
                                begin
                                    if (item_reg.attr_length < 16'd4)
                                        attr_err = rumc_pkg::ST_LENGTH;
                                    else if (!item_reg.as_path_ok)
                                        attr_err = rumc_pkg::ST_ASPATH;
                                end
                                rumc_pkg::ATTR_NEXT_HOP:
                                begin
                                    if (item_reg.attr_length != 16'd4 || !hop_ok)
                                        attr_err = rumc_pkg::ST_NEXTHOP;
                                end
                                rumc_pkg::ATTR_MED, rumc_pkg::ATTR_LOCAL_PREF:
                                begin
                                    if (item_reg.attr_length != 16'd4)
                                        attr_err = rumc_pkg::ST_LENGTH;
                                end
                                rumc_pkg::ATTR_ATOMIC_AGG:
                                begin
                                    if (item_reg.attr_length != 16'd0)
                                        attr_err = rumc_pkg::ST_LENGTH;
                                end
                                default:
                                begin
                                    if (item_reg.attr_length != 16'd6)
                                        attr_err = rumc_pkg::ST_LENGTH;
                                end
                            endcase
                        end
                    end
                    // Optional, non-transitive yet partial is a bad flag mix
                    if (attr_err == rumc_pkg::ST_OK && item_reg.attr_flags[7]
                        && !item_reg.attr_flags[6] && item_reg.attr_flags[5])
                        attr_err = rumc_pkg::ST_FLAGS;
                    err_next = attr_err;
                end
            end
            rumc_pkg::REQ_ATTR_END:
            begin
                // Report the first absent mandatory attribute
                if (err_reg == rumc_pkg::ST_OK && present_reg)
                begin
                    if (!seen_reg[0])
                    begin
                        err_next  = rumc_pkg::ST_MISSING;
                        miss_next = 2'(rumc_pkg::ATTR_ORIGIN);
                    end
                    else if (!seen_reg[1])
                    begin
                        err_next  = rumc_pkg::ST_MISSING;
                        miss_next = 2'(rumc_pkg::ATTR_AS_PATH);
                    end
                    else if (!seen_reg[2])
                    begin
                        err_next  = rumc_pkg::ST_MISSING;
                        miss_next = 2'(rumc_pkg::ATTR_NEXT_HOP);
                    end
                end
            end
            rumc_pkg::REQ_NLRI_BYTE:
            begin
                // Take a prefix length, or count down its owed bytes
                if (err_reg == rumc_pkg::ST_OK)
                begin
                    if (left_reg == 3'd0)
                    begin
                        if (item_reg.nlri_byte > rumc_pkg::MAX_PREFIX_BITS)
                            err_next = rumc_pkg::ST_NETWORK;
                        else
                            left_next = prefix_round[5:3];
                    end
                    else
                    begin
                        left_next = left_reg - 3'd1;
                    end
                end
            end
            rumc_pkg::REQ_MSG_END:
            begin
                if (err_reg == rumc_pkg::ST_OK && left_reg != 3'd0)
                    err_next = rumc_pkg::ST_NETWORK;
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // Message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 7'd0;
            err_reg     <= rumc_pkg::ST_OK;
            miss_reg    <= 2'd0;
            left_reg    <= 3'd0;
            present_reg <= 1'b0;
        end
        else if (advance)
        begin
            seen_reg    <= seen_next;
            err_reg     <= err_next;
            miss_reg    <= miss_next;
            left_reg    <= left_next;
            present_reg <= present_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!(result_valid_reg && result_stall))
        begin
            result_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.status        <= err_next;
            result_reg.missing_attr  <= miss_next;
            result_reg.verdict_done  <= done;
            result_reg.message_valid <= done && (err_next == rumc_pkg::ST_OK);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `RUMC_ASSERT_NOW(a_valid_means_clean_end, clk, rst_n,
        result_valid_reg && result_reg.message_valid,
        result_reg.verdict_done && result_reg.status == rumc_pkg::ST_OK,
        "message_valid without a clean message end")
    `RUMC_ASSERT_NOW(a_missing_has_status, clk, rst_n,
        result_valid_reg && result_reg.missing_attr != 2'd0,
        result_reg.status == rumc_pkg::ST_MISSING || result_reg.status == rumc_pkg::ST_LIST
        || result_reg.status == rumc_pkg::ST_FLAGS || result_reg.status == rumc_pkg::ST_LENGTH
        || result_reg.status == rumc_pkg::ST_ORIGIN || result_reg.status == rumc_pkg::ST_NEXTHOP
        || result_reg.status == rumc_pkg::ST_NETWORK || result_reg.status == rumc_pkg::ST_ASPATH,
        "missing attribute reported with ok status")
    `RUMC_ASSERT_NEXT(a_error_latched, clk, rst_n,
        advance && err_reg != rumc_pkg::ST_OK && item_reg.req_type != rumc_pkg::REQ_START,
        err_reg == $past(err_reg),
        "latched error changed without a start item")

endmodule

### verif/route_update_message_checker_scoreboard.sv
package rumc_scoreboard_pkg;

    import rumc_pkg::*;

    class verdict_scoreboard;

        // Message state as the block should hold it
        logic [6:0] seen_types;
        logic [3:0] latched_status;
        logic [1:0] missing_type;
        logic [2:0] prefix_owed;
        logic       list_present;

        // Results still to arrive, oldest first
        out_item_t  pending_results[$];

        int mismatches;
        int results_checked;
        int verdicts;
        int valid_verdicts;

        function new();
            clear_message();
            mismatches      = 0;
            results_checked = 0;
            verdicts        = 0;
            valid_verdicts  = 0;
        endfunction

        function void clear_message();
            seen_types     = 7'b0;
            latched_status = ST_OK;
            missing_type   = 2'd0;
            prefix_owed    = 3'd0;
            list_present   = 1'b0;
        endfunction

        // Reject zero, multicast, 10/8, 172.16/16 and 192.168.0/24
        function bit next_hop_allowed(logic [31:0] addr);
            if (addr == 32'h0000_0000)
                return 1'b0;
            if (addr >= 32'hE000_0000 && addr <= 32'hEFFF_FFFF)
                return 1'b0;
            if (addr >= 32'h0A00_0000 && addr <= 32'h0AFF_FFFF)
                return 1'b0;
            if (addr >= 32'hAC10_0000 && addr <= 32'hAC10_FFFF)
                return 1'b0;
            if (addr >= 32'hC0A8_0000 && addr <= 32'hC0A8_00FF)
                return 1'b0;
            return 1'b1;
        endfunction

        // Status caused by one path attribute; marks known types as seen
        function logic [3:0] attribute_status(in_item_t it);
            logic [6:0] type_bit;
            if (it.attr_type >= 8'd1 && it.attr_type <= 8'd7)
            begin
                type_bit = 7'b1 << (it.attr_type - 8'd1);
                if ((seen_types & type_bit) != 7'b0)
                    return ST_LIST;
                seen_types = seen_types | type_bit;
                case (it.attr_type[2:0])
                    ATTR_ORIGIN:
                    begin
                        if (it.attr_length != 16'd1)
                            return ST_LENGTH;
                        if (it.value_word[31:24] > 8'd2)
                            return ST_ORIGIN;
                    end
                    ATTR_AS_PATH:
                    begin
                        if (it.attr_length < 16'd4)
                            return ST_LENGTH;
                        if (!it.as_path_ok)
                            return ST_ASPATH;
                    end
                    ATTR_NEXT_HOP:
                        if (it.attr_length != 16'd4 || !next_hop_allowed(it.value_word))
                            return ST_NEXTHOP;
                    ATTR_MED, ATTR_LOCAL_PREF:
                        if (it.attr_length != 16'd4)
                            return ST_LENGTH;
                    ATTR_ATOMIC_AGG:
                        if (it.attr_length != 16'd0)
                            return ST_LENGTH;
                    default:
                        if (it.attr_length != 16'd6)
                            return ST_LENGTH;
                endcase
            end
            // Optional, non-transitive and partial together is illegal
            if (it.attr_flags[7] && !it.attr_flags[6] && it.attr_flags[5])
                return ST_FLAGS;
            return ST_OK;
        endfunction

        // Advance the state by one accepted item and queue its result
        function void note_item(in_item_t it);
            out_item_t res;
            int        owed_bytes;
            logic      done;
            done = 1'b0;
            case (it.req_type)
                REQ_START:
                begin
                    clear_message();
                    list_present = (it.attributes_length != 13'd0);
                    if (int'(it.message_length) < int'(it.withdrawn_length)
                        + int'(it.attributes_length) + int'(MSG_OVERHEAD))
                        latched_status = ST_LIST;
                end
                REQ_ATTR:
                    if (latched_status == ST_OK && list_present)
                        latched_status = attribute_status(it);
                REQ_ATTR_END:
                    if (latched_status == ST_OK && list_present)
                    begin
                        if (!seen_types[0])
                        begin
                            latched_status = ST_MISSING;
                            missing_type   = ATTR_ORIGIN[1:0];
                        end
                        else if (!seen_types[1])
                        begin
                            latched_status = ST_MISSING;
                            missing_type   = ATTR_AS_PATH[1:0];
                        end
                        else if (!seen_types[2])
                        begin
                            latched_status = ST_MISSING;
                            missing_type   = ATTR_NEXT_HOP[1:0];
                        end
                    end
                REQ_NLRI_BYTE:
                    if (latched_status == ST_OK)
                    begin
                        if (prefix_owed != 3'd0)
                            prefix_owed = prefix_owed - 3'd1;
                        else if (it.nlri_byte > MAX_PREFIX_BITS)
                            latched_status = ST_NETWORK;
                        else
                        begin
                            owed_bytes  = (int'(it.nlri_byte) + 7) / 8;
                            prefix_owed = owed_bytes[2:0];
                        end
                    end
                REQ_MSG_END:
                begin
                    if (latched_status == ST_OK && prefix_owed != 3'd0)
                        latched_status = ST_NETWORK;
                    done = 1'b1;
                end
                default:
                    ;
            endcase
            res.status        = latched_status;
            res.missing_attr  = missing_type;
            res.verdict_done  = done;
            res.message_valid = done && (latched_status == ST_OK);
            pending_results.insert(pending_results.size(), res);
        endfunction

        task report(string field, int got, int want);
            mismatches++;
            if (mismatches <= 200)
                $display("mismatch on result %0d: %s is %0d, expected %0d",
                         results_checked, field, got, want);
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(out_item_t got);
            out_item_t want;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                report("unrequested result, status", got.status, -1);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.missing_attr != want.missing_attr)
                report("missing_attr", got.missing_attr, want.missing_attr);
            if (got.verdict_done != want.verdict_done)
                report("verdict_done", got.verdict_done, want.verdict_done);
            if (got.message_valid != want.message_valid)
                report("message_valid", got.message_valid, want.message_valid);
            if (want.verdict_done)
            begin
                verdicts++;
                if (want.message_valid)
                    valid_verdicts++;
            end
        endtask

    endclass

endpackage

### verif/route_update_message_checker_test.sv
module route_update_message_checker_test;

    import rumc_pkg::*;
    import rumc_scoreboard_pkg::*;

    localparam logic [2:0] REQ_UNUSED = 3'd5;
    localparam int ITEM_TARGET = 1450;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 5000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    verdict_scoreboard status_model;
    in_item_t          msg_items[$];

    int items_sent  = 0;
    int msg_count   = 0;
    int holds_done  = 0;
    int drains_done = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    // Next-hop range edges, inside each excluded range and just outside each but zero
    logic [31:0] hop_edges [16] = '{
        32'h0000_0000, 32'hE000_0000, 32'hEFFF_FFFF, 32'h0A00_0000,
        32'h0AFF_FFFF, 32'hAC10_0000, 32'hAC10_FFFF, 32'hC0A8_0000,
        32'hC0A8_00FF, 32'hDFFF_FFFF, 32'hF000_0000, 32'h09FF_FFFF,
        32'h0B00_0000, 32'hAC0F_FFFF, 32'hAC11_0000, 32'hC0A8_0100
    };

    always #5 clk = ~clk;

    route_update_message_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fill every field with random content
    function automatic in_item_t noise_item();
        in_item_t it;
        it.req_type          = 3'($urandom_range(0, 7));
        it.message_length    = 13'($urandom_range(0, 8191));
        it.withdrawn_length  = 13'($urandom_range(0, 8191));
        it.attributes_length = 13'($urandom_range(0, 8191));
        it.attr_type         = 8'($urandom_range(0, 255));
        it.attr_flags        = 8'($urandom_range(0, 255));
        it.attr_length       = 16'($urandom_range(0, 65535));
        it.value_word        = $urandom;
        it.as_path_ok        = 1'($urandom_range(0, 1));
        it.nlri_byte         = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic in_item_t start_item(int unsigned mlen, int unsigned wlen,
                                            int unsigned alen);
        in_item_t it;
        it                   = noise_item();
        it.req_type          = REQ_START;
        it.message_length    = 13'(mlen);
        it.withdrawn_length  = 13'(wlen);
        it.attributes_length = 13'(alen);
        return it;
    endfunction

    function automatic in_item_t attribute_item(logic [7:0] code, logic [7:0] flags,
                                                logic [15:0] len, logic [31:0] word,
                                                logic path_ok);
        in_item_t it;
        it             = noise_item();
        it.req_type    = REQ_ATTR;
        it.attr_type   = code;
        it.attr_flags  = flags;
        it.attr_length = len;
        it.value_word  = word;
        it.as_path_ok  = path_ok;
        return it;
    endfunction

    function automatic in_item_t control_item(logic [2:0] req);
        in_item_t it;
        it          = noise_item();
        it.req_type = req;
        return it;
    endfunction

    function automatic in_item_t nlri_item(logic [7:0] value);
        in_item_t it;
        it           = noise_item();
        it.req_type  = REQ_NLRI_BYTE;
        it.nlri_byte = value;
        return it;
    endfunction

    // Append one item to the message being built
    function automatic void queue_item(in_item_t it);
        msg_items.insert(msg_items.size(), it);
    endfunction

    // Offer one item, hold it until accepted, then record it
    task automatic send_item(input in_item_t it);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        status_model.note_item(it);
        if (it.req_type <= REQ_MSG_END)
            items_sent++;
    endtask

    task automatic send_message();
        foreach (msg_items[i])
            send_item(msg_items[i]);
        msg_items.delete();
    endtask

    // Pause the sender until every outstanding result is back
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (status_model.pending_results.size() != 0)
            @(posedge clk);
        drains_done++;
    endtask

    // Queue one message; fault_pct sets how often a rule is broken
    task automatic build_message(input int fault_pct);
        int unsigned wlen;
        int unsigned alen;
        int unsigned mlen;
        int unsigned floor_len;
        logic [7:0]  codes[$];
        logic [7:0]  tmp_code;
        logic [7:0]  flags;
        logic [15:0] len;
        logic [31:0] word;
        logic        path_ok;
        int          j;
        int          k;
        int          n_pref;
        int          plen;
        int          nbytes;

        // Lengths, with the occasional extreme or empty list
        wlen = roll(5) ? $urandom_range(0, 8191) : $urandom_range(0, 60);
        if (roll(8))
            alen = 0;
        else if (roll(5))
            alen = $urandom_range(1, 8191);
        else
            alen = $urandom_range(1, 400);
        floor_len = wlen + alen + 23;
        if (roll(fault_pct))
            mlen = $urandom_range(0, floor_len - 1);
        else
            mlen = roll(25) ? floor_len : floor_len + $urandom_range(1, 40);
        if (mlen > 8191)
            mlen = 8191;
        queue_item(start_item(mlen, wlen, alen));

        // Mandatory types, some optional ones and a few unknown codes
        codes.insert(codes.size(), 8'(ATTR_ORIGIN));
        codes.insert(codes.size(), 8'(ATTR_AS_PATH));
        codes.insert(codes.size(), 8'(ATTR_NEXT_HOP));
        for (k = int'(ATTR_MED); k <= int'(ATTR_AGGREGATOR); k++)
            if (roll(50))
                codes.insert(codes.size(), 8'(k));
        repeat ($urandom_range(0, 2))
        begin
            tmp_code = roll(15) ? 8'd0 : 8'($urandom_range(8, 255));
            codes.insert(codes.size(), tmp_code);
        end
        if (roll(fault_pct))
            codes.delete($urandom_range(0, 2));
        if (roll(fault_pct))
            codes.insert(codes.size(), codes[$urandom_range(0, codes.size() - 1)]);

        // Shuffle the attribute order
        for (j = codes.size() - 1; j > 0; j--)
        begin
            k        = $urandom_range(0, j);
            tmp_code = codes[j];
            codes[j] = codes[k];
            codes[k] = tmp_code;
        end

        foreach (codes[i])
        begin
            flags = 8'($urandom_range(0, 255));
            if (flags[7:5] == 3'b101 && !roll(fault_pct))
                flags[6] = 1'b1;
            word    = $urandom;
            path_ok = 1'b1;
            case (codes[i])
                ATTR_ORIGIN:
                begin
                    len          = 16'd1;
                    word[31:24]  = 8'($urandom_range(0, 2));
                    if (roll(fault_pct))
                        word[31:24] = 8'($urandom_range(3, 255));
                end
                ATTR_AS_PATH:
                begin
                    len = 16'($urandom_range(4, 64));
                    if (roll(fault_pct))
                        path_ok = 1'b0;
                end
                ATTR_NEXT_HOP:
                begin
                    len = 16'd4;
                    do
                        word = $urandom;
                    while (!status_model.next_hop_allowed(word));
                    k = $urandom_range(0, 15);
                    if (roll(20) && status_model.next_hop_allowed(hop_edges[k]))
                        word = hop_edges[k];
                    if (roll(fault_pct * 3))
                        word = hop_edges[k];
                end
                ATTR_MED, ATTR_LOCAL_PREF:
                    len = 16'd4;
                ATTR_ATOMIC_AGG:
                    len = 16'd0;
                ATTR_AGGREGATOR:
                    len = 16'd6;
                default:
                    len = roll(50) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 8));
            endcase
            if (roll(fault_pct))
                len = 16'($urandom_range(0, 8));
            queue_item(attribute_item(codes[i], flags, len, word, path_ok));
        end
        queue_item(control_item(REQ_ATTR_END));

        // Reachability prefixes, each length byte followed by its bytes
        n_pref = $urandom_range(0, 4);
        for (j = 0; j < n_pref; j++)
        begin
            plen = $urandom_range(0, 32);
            if (roll(fault_pct))
                plen = $urandom_range(33, 255);
            queue_item(nlri_item(8'(plen)));
            nbytes = (plen > 32) ? 0 : (plen + 7) / 8;
            if (j == n_pref - 1 && nbytes > 0 && roll(fault_pct * 2))
                nbytes--;
            repeat (nbytes)
                queue_item(nlri_item(8'($urandom_range(0, 255))));
        end
        queue_item(control_item(REQ_MSG_END));
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_side
        int stall_run;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                stall_run = LONG_HOLD;
                holds_done++;
            end
            else if (stall_run == 0 && !quiet && roll(25))
                stall_run = pick_gap();
            if (stall_run > 0)
            begin
                result_stall <= 1'b1;
                stall_run--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            status_model.check_result(result);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int r;
        status_model = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Items ahead of any start item, then an unused request code
        queue_item(nlri_item(8'd33));
        queue_item(control_item(REQ_UNUSED));
        // Too short a message; the later attribute error must not replace it
        queue_item(start_item(0, 0, 0));
        queue_item(attribute_item(8'(ATTR_ORIGIN), 8'h40, 16'd1, 32'h0300_0000, 1'b1));
        queue_item(control_item(REQ_MSG_END));
        // No attribute list: attributes ignored, no mandatory check, bad prefix
        queue_item(start_item(8191, 0, 0));
        queue_item(attribute_item(8'(ATTR_ORIGIN), 8'hA0, 16'd7, 32'hFFFF_FFFF, 1'b0));
        queue_item(control_item(REQ_ATTR_END));
        queue_item(nlri_item(8'd255));
        queue_item(control_item(REQ_MSG_END));
        // Clean message at the exact length bound with every attribute type
        queue_item(start_item(63, 10, 30));
        queue_item(attribute_item(8'(ATTR_ORIGIN), 8'h40, 16'd1, 32'h02FF_FFFF, 1'b0));
        queue_item(attribute_item(8'(ATTR_AS_PATH), 8'h50, 16'd4, 32'h0, 1'b1));
        queue_item(attribute_item(8'(ATTR_NEXT_HOP), 8'h40, 16'd4, 32'hAC11_0000, 1'b0));
        queue_item(attribute_item(8'(ATTR_MED), 8'h80, 16'd4, 32'h0, 1'b0));
        queue_item(attribute_item(8'(ATTR_LOCAL_PREF), 8'h40, 16'd4, 32'h0, 1'b0));
        queue_item(attribute_item(8'(ATTR_ATOMIC_AGG), 8'hC0, 16'd0, 32'h0, 1'b0));
        queue_item(attribute_item(8'(ATTR_AGGREGATOR), 8'hE0, 16'd6, 32'h0, 1'b0));
        queue_item(attribute_item(8'd255, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
        queue_item(control_item(REQ_ATTR_END));
        queue_item(nlri_item(8'd9));
        queue_item(nlri_item(8'hFF));
        queue_item(nlri_item(8'h00));
        queue_item(nlri_item(8'd0));
        queue_item(control_item(REQ_MSG_END));
        send_message();

        // Random messages: mostly well-formed, some faulty, some noise
        while (items_sent < ITEM_TARGET)
        begin
            quiet = roll(20);
            if (msg_count % 40 == 10)
            begin
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            if (msg_count % 40 == 30)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 70)
                build_message(0);
            else if (r < 90)
            begin
                build_message(10);
                if (roll(30))
                    msg_items.delete($urandom_range(0, msg_items.size() - 1));
            end
            else
                repeat ($urandom_range(1, 12))
                    queue_item(noise_item());
            send_message();
            msg_count++;
        end

        // Let every result come back
        drain_results();
        repeat (8) @(posedge clk);

        $display("covered %0d items in %0d random messages plus directed ones",
                 items_sent, msg_count);
        $display("%0d verdicts, %0d valid; result side held off %0d times for %0d cycles, %s %0d",
                 status_model.verdicts, status_model.valid_verdicts, holds_done, LONG_HOLD,
                 "sender drained", drains_done);
        if (status_model.mismatches == 0 && status_model.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/rumc_pkg.sv
rtl/route_update_message_checker.sv
verif/route_update_message_checker_scoreboard.sv
verif/route_update_message_checker_test.sv
